>>> hdl/pcr_extend_sha256_assert.svh
// Assertion macros shared by the checker of the measurement extend engine.
// Holds macro definitions only.
`ifndef PCR_EXTEND_SHA256_ASSERT_SVH
`define PCR_EXTEND_SHA256_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PCRX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PCRX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hdl/pcrx_pkg.sv
// Shared types, constants and functions for the measurement extend engine.
// No dependencies.
`timescale 1ns / 1ps
package pcrx_pkg;
    localparam int PCR_BYTES = 32;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Which compression the back part is running.
    localparam logic [1:0] PH_EVENT      = 2'd0;
    localparam logic [1:0] PH_EVENT_LAST = 2'd1;
    localparam logic [1:0] PH_EXT_MSG    = 2'd2;
    localparam logic [1:0] PH_EXT_PAD    = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] pcr_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Queue entry from the front part: a byte to absorb or an end-of-event marker.
    typedef struct packed {
        logic       is_end;
        logic [7:0] data_byte;
    } t_work;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_COMP_LOAD, S_COMP_RUN, S_COMP_ADD, S_EXT_LOAD, S_EMIT
    } t_state;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

>>> hdl/pcr_extend_sha256.sv
// Measurement register extend engine: SHA-256 event digest, then register extend.
// Data bytes pass through a four-beat queue, and the SHA-256 rounds run after every
// 64th byte; the input stalls only while the queue is full.
// End of event: padding, one or two compressions, one load step and two more
// compressions, then four result beats. Synchronous active-low reset zeroes the register.
`timescale 1ns / 1ps
module pcr_extend_sha256 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pcrx_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output pcrx_pkg::t_out_item o_data
);
    import pcrx_pkg::*;

    logic  work_valid, work_pop;
    t_work work;

    pcrx_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_work_valid(work_valid), .i_work_pop(work_pop), .o_work(work)
    );

    pcrx_back u_back (
        .i_clk, .i_rst_n, .i_work_valid(work_valid), .i_work(work),
        .o_work_pop(work_pop), .o_valid, .i_stall, .o_data
    );
endmodule

>>> hdl/pcrx_front.sv
// Front part: accepts input beats, classifies them and queues work entries.
// Depends on pcrx_pkg.
`timescale 1ns / 1ps
module pcrx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pcrx_pkg::t_in_item i_data,
    output logic              o_work_valid,
    input  logic              i_work_pop,
    output pcrx_pkg::t_work   o_work
);
    import pcrx_pkg::*;

    localparam int DEPTH = 4;

    t_work      r_mem [DEPTH];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic       push;

    assign o_stall      = (r_cnt == 3'(DEPTH));
    assign push         = i_valid && !o_stall;
    assign o_work_valid = (r_cnt != 3'd0);
    assign o_work       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr].is_end    <= (i_data.cmd == CMD_END);
            r_mem[r_wr].data_byte <= i_data.data_byte;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 2'd1;
            if (i_work_pop) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(i_work_pop);
        end
    end
endmodule

>>> hdl/pcrx_back.sv
// Back part: absorbs bytes, runs the SHA-256 rounds one per cycle, extends the
// register and emits four result words. Depends on pcrx_pkg.
`timescale 1ns / 1ps
module pcrx_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_work_valid,
    input  pcrx_pkg::t_work    i_work,
    output logic               o_work_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output pcrx_pkg::t_out_item o_data
);
    import pcrx_pkg::*;

    t_state       r_state, n_state;
    logic [31:0]  r_h [8];
    logic [31:0]  r_st [8];
    logic [31:0]  r_blk [16];
    logic [31:0]  r_w [16];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;
    logic [63:0]  r_cnt;
    logic [63:0]  r_bits;
    logic [8*PCR_BYTES-1:0] r_pcr;
    logic [5:0]   r_round;
    logic [1:0]   r_phase;
    logic         r_padding;
    logic         r_len_blk;
    logic [7:0]   r_byte;
    logic [1:0]   r_idx;
    logic         r_out_valid;

    logic [5:0]   pos, next_pos;
    logic [2:0]   len_sel;
    logic [7:0]   pad_next, blk_byte;
    logic         blk_wr, is_ext;
    logic [31:0]  t1, t2, s0, s1, wnew;
    logic [31:0]  src [8];
    logic [31:0]  sum [8];

    assign pos      = r_cnt[5:0];
    assign next_pos = pos + 6'd1;
    assign len_sel  = 3'd7 - next_pos[2:0];
    // Length bytes go at places 56 to 63 of the block that closes the padding.
    assign pad_next = (r_len_blk && next_pos >= 6'd56) ? r_bits[{len_sel, 3'b000} +: 8]
                                                       : 8'h00;
    assign blk_wr   = ((r_state == S_IDLE) && i_work_valid && !i_work.is_end)
                      || (r_state == S_PAD);
    assign blk_byte = (r_state == S_PAD) ? r_byte : i_work.data_byte;
    assign is_ext   = (r_phase == PH_EXT_MSG) || (r_phase == PH_EXT_PAD);

    assign s0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign wnew = r_w[0] + s0 + r_w[9] + s1;
    assign t1   = r_hh + (rotr(r_e, 6) ^ rotr(r_e, 11) ^ rotr(r_e, 25))
                + ((r_e & r_f) ^ (~r_e & r_g)) + ROUND_K[r_round] + r_w[0];
    assign t2   = (rotr(r_a, 2) ^ rotr(r_a, 13) ^ rotr(r_a, 22))
                + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    always_comb begin
        for (int i = 0; i < 8; i++) src[i] = is_ext ? r_st[i] : r_h[i];
        sum[0] = src[0] + r_a;
        sum[1] = src[1] + r_b;
        sum[2] = src[2] + r_c;
        sum[3] = src[3] + r_d;
        sum[4] = src[4] + r_e;
        sum[5] = src[5] + r_f;
        sum[6] = src[6] + r_g;
        sum[7] = src[7] + r_hh;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_work_valid) begin
                    if (i_work.is_end) n_state = S_PAD;
                    else if (pos == 6'd63) n_state = S_COMP_LOAD;
                end
            end
            S_PAD:
                if (pos == 6'd63) n_state = S_COMP_LOAD;
            S_COMP_LOAD:
                n_state = S_COMP_RUN;
            S_COMP_RUN:
                if (r_round == 6'd63) n_state = S_COMP_ADD;
            S_COMP_ADD: begin
                case (r_phase)
                    PH_EVENT:      n_state = r_padding ? S_PAD : S_IDLE;
                    PH_EVENT_LAST: n_state = S_EXT_LOAD;
                    PH_EXT_MSG:    n_state = S_COMP_LOAD;
                    default:       n_state = S_EMIT;
                endcase
            end
            S_EXT_LOAD:
                n_state = S_COMP_LOAD;
            S_EMIT:
                if (r_out_valid && !i_stall && r_idx == 2'd3) n_state = S_IDLE;
            default:
                n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_work_pop = (r_state == S_IDLE) && i_work_valid;
        o_valid    = r_out_valid;
        case (r_idx)
            2'd0:    o_data.pcr_word = r_pcr[255:192];
            2'd1:    o_data.pcr_word = r_pcr[191:128];
            2'd2:    o_data.pcr_word = r_pcr[127:64];
            default: o_data.pcr_word = r_pcr[63:0];
        endcase
        o_data.word_index = r_idx;
        o_data.last_word  = (r_idx == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pcr       <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_phase     <= PH_EVENT;
            r_padding   <= 1'b0;
            r_len_blk   <= 1'b0;
            r_bits      <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_H[i];
        end else begin
            r_state <= n_state;
            if (blk_wr) begin
                // Byte lands at its big-endian place in the block word.
                case (pos[1:0])
                    2'd0:    r_blk[pos[5:2]][31:24] <= blk_byte;
                    2'd1:    r_blk[pos[5:2]][23:16] <= blk_byte;
                    2'd2:    r_blk[pos[5:2]][15:8]  <= blk_byte;
                    default: r_blk[pos[5:2]][7:0]   <= blk_byte;
                endcase
                r_cnt <= r_cnt + 64'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_work_valid && i_work.is_end) begin
                        r_bits    <= {r_cnt[60:0], 3'b000};
                        r_byte    <= 8'h80;
                        r_padding <= 1'b1;
                        r_len_blk <= (pos < 6'd56);
                    end
                    r_phase <= PH_EVENT;
                end
                S_PAD: begin
                    r_byte <= pad_next;
                    if (pos == 6'd63) r_phase <= r_len_blk ? PH_EVENT_LAST : PH_EVENT;
                end
                S_COMP_LOAD: begin
                    for (int i = 0; i < 16; i++) r_w[i] <= r_blk[i];
                    r_a <= src[0]; r_b <= src[1]; r_c <= src[2]; r_d <= src[3];
                    r_e <= src[4]; r_f <= src[5]; r_g <= src[6]; r_hh <= src[7];
                    r_round <= '0;
                end
                S_COMP_RUN: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= wnew;
                    r_hh <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
                    r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
                    r_round <= r_round + 6'd1;
                end
                S_COMP_ADD: begin
                    case (r_phase)
                        PH_EVENT: begin
                            for (int i = 0; i < 8; i++) r_h[i] <= sum[i];
                            // A padding block without the length puts it in the next one.
                            r_len_blk <= 1'b1;
                        end
                        PH_EVENT_LAST: begin
                            for (int i = 0; i < 8; i++) r_h[i] <= sum[i];
                        end
                        PH_EXT_MSG: begin
                            for (int i = 0; i < 8; i++) r_st[i] <= sum[i];
                            for (int i = 0; i < 16; i++) begin
                                r_blk[i] <= (i == 0) ? 32'h80000000
                                          : (i == 15) ? 32'd512 : 32'd0;
                            end
                            r_phase <= PH_EXT_PAD;
                        end
                        default: begin
                            r_pcr <= {sum[0], sum[1], sum[2], sum[3],
                                      sum[4], sum[5], sum[6], sum[7]};
                            r_out_valid <= 1'b1;
                            r_idx <= '0;
                        end
                    endcase
                end
                S_EXT_LOAD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_blk[i]     <= r_pcr[255 - 32 * i -: 32];
                        r_blk[8 + i] <= r_h[i];
                        r_st[i]      <= INIT_H[i];
                        r_h[i]       <= INIT_H[i];
                    end
                    r_cnt     <= '0;
                    r_phase   <= PH_EXT_MSG;
                    r_padding <= 1'b0;
                end
                S_EMIT: begin
                    if (r_out_valid && !i_stall) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == 2'd3) r_out_valid <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> hdl/pcrx_checker.sv
// Port-level checker for the measurement extend engine, bound to the top level.
// Depends on pcrx_pkg and pcr_extend_sha256_assert.svh.
`timescale 1ns / 1ps
`include "pcr_extend_sha256_assert.svh"
module pcrx_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input pcrx_pkg::t_out_item o_data
);
    import pcrx_pkg::*;
    `PCRX_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `PCRX_ASSERT_IMP(a_last, i_clk, i_rst_n, o_valid, o_data.last_word == (o_data.word_index == 2'd3))
    `PCRX_ASSERT_NEXT(a_seq, i_clk, i_rst_n, o_valid && !i_stall && !o_data.last_word,
        o_valid && o_data.word_index == $past(o_data.word_index) + 2'd1)
endmodule

bind pcr_extend_sha256 pcrx_checker u_chk (.*);

>>> bench/tb_pcr_extend_sha256.sv
// Self-checking bench for the SHA-256 measurement register extend engine.
// Predicts every register update in SHA-256 terms and checks each output beat.
// Depends on pcrx_pkg and pcr_extend_sha256.
`timescale 1ns / 1ps
module tb_pcr_extend_sha256;
    import pcrx_pkg::*;

    typedef logic [0:7][31:0]  t_words8;
    typedef logic [0:15][31:0] t_words16;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    pcr_extend_sha256 DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    // Predicted engine state.
    logic [63:0] pcr_model [4];
    t_words8     event_hash;
    t_words16    msg_block;
    logic [63:0] msg_count;

    t_out_item pcr_words_due [$];
    int        errors;
    bit        quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("pcr_extend_sha256 test failed");
        $finish;
    end

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_words8 sha_init();
        t_words8 h;
        for (int i = 0; i < 8; i++) h[i] = INIT_H[i];
        return h;
    endfunction

    function automatic t_words8 sha_compress(t_words8 h, t_words16 b);
        logic [31:0] w [64];
        logic [31:0] a, bb, c, d, e, f, g, hh, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = b[i];
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = h[0]; bb = h[1]; c = h[2]; d = h[3];
        e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (int i = 0; i < 64; i++) begin
            t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & bb) ^ (a & c) ^ (bb & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = bb; bb = a; a = t1 + t2;
        end
        h[0] += a; h[1] += bb; h[2] += c; h[3] += d;
        h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
        return h;
    endfunction

    task automatic absorb_byte(logic [7:0] b);
        logic [5:0] pos;
        int         sh;
        pos = msg_count[5:0];
        sh = (3 - pos[1:0]) * 8;
        if (pos[1:0] == 2'd0) msg_block[pos >> 2] = 32'(b) << sh;
        else msg_block[pos >> 2] |= 32'(b) << sh;
        msg_count++;
        if (pos == 6'd63) event_hash = sha_compress(event_hash, msg_block);
    endtask

    // Closes the event digest and extends the register; queues the four new words.
    task automatic extend_register();
        logic [63:0] bits;
        t_words8     st;
        t_words16    blk;
        t_out_item   w;
        bits = msg_count << 3;
        absorb_byte(8'h80);
        while (msg_count[5:0] != 6'd56) absorb_byte(8'h00);
        for (int i = 0; i < 8; i++) absorb_byte(bits[63 - 8*i -: 8]);
        st = sha_init();
        for (int i = 0; i < 4; i++) begin
            blk[2*i]   = pcr_model[i][63:32];
            blk[2*i+1] = pcr_model[i][31:0];
        end
        for (int i = 0; i < 8; i++) blk[8+i] = event_hash[i];
        st = sha_compress(st, blk);
        blk = '0;
        blk[0] = 32'h80000000;
        blk[15] = 32'd512;
        st = sha_compress(st, blk);
        for (int i = 0; i < 4; i++) begin
            pcr_model[i] = {st[2*i], st[2*i+1]};
            w.pcr_word = pcr_model[i];
            w.word_index = 2'(i);
            w.last_word = (i == 3);
            pcr_words_due.push_back(w);
        end
        event_hash = sha_init();
        msg_count = '0;
    endtask

    // Sends one beat; valid stays high afterwards until the next gap.
    task automatic send_item(logic cmd, logic [7:0] b);
        t_in_item it;
        it.cmd = cmd;
        it.data_byte = b;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
        if (cmd == CMD_END) extend_register();
        else absorb_byte(b);
    endtask

    task automatic send_event(int len);
        for (int i = 0; i < len; i++) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        send_item(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 55;
            1: return 56;
            2: return 63 + $urandom_range(0, 1);
            3: return 119 + $urandom_range(0, 2);
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    // Empty events, with end-of-event beats carrying zero and non-zero byte fields.
    task automatic test_empty_events();
        send_item(CMD_END, 8'h00);
        send_item(CMD_END, 8'hff);
        send_item(CMD_END, 8'h5a);
    endtask

    task automatic test_byte_extremes();
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_END, 8'h00);
        send_item(CMD_BYTE, 8'hff);
        send_item(CMD_END, 8'hff);
        send_item(CMD_BYTE, 8'h80);
        send_item(CMD_BYTE, 8'h01);
        send_item(CMD_END, 8'h00);
    endtask

    task automatic test_random_events(int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            len = pick_length();
            send_event(len);
            sent += len + 1;
        end
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        send_event(3);
        send_event(64);
        send_event(0);
    endtask

    // Result side: random stall bursts and the field check.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pcr_words_due.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, o_data);
                    errors++;
                end else begin
                    t_out_item want;
                    want = pcr_words_due.pop_front();
                    if (o_data.pcr_word !== want.pcr_word) begin
                        $display("%0t: pcr_word expected %h actual %h",
                                 $time, want.pcr_word, o_data.pcr_word);
                        errors++;
                    end
                    if (o_data.word_index !== want.word_index) begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, want.word_index, o_data.word_index);
                        errors++;
                    end
                    if (o_data.last_word !== want.last_word) begin
                        $display("%0t: last_word expected %0d actual %0d",
                                 $time, want.last_word, o_data.last_word);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 4);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        errors = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        for (int i = 0; i < 4; i++) pcr_model[i] = '0;
        event_hash = sha_init();
        msg_block = '0;
        msg_count = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_events();
        test_byte_extremes();
        test_random_events(290);
        test_quiet_tail();
        i_valid <= 1'b0;

        wait (pcr_words_due.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("pcr_extend_sha256 test passed");
        else $display("pcr_extend_sha256 test failed");
        $finish;
    end
endmodule
